FILE: rtl/gsp_pkg.sv
// Package with shared constants, types and command codes of the shortest path engine.
package gsp_pkg;
  localparam int NumVerts = 16;
  localparam int VIdxW = 4;
  localparam int WeightW = 16;
  localparam int DistW = 20;

  localparam logic [2:0] KindAddVertex = 3'd0;
  localparam logic [2:0] KindRemVertex = 3'd1;
  localparam logic [2:0] KindAddEdge   = 3'd2;
  localparam logic [2:0] KindRemEdge   = 3'd3;
  localparam logic [2:0] KindSolve     = 3'd4;

  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatNoVertex = 2'd1;
  localparam logic [1:0] StatPresent  = 2'd2;
  localparam logic [1:0] StatRefused  = 2'd3;

  typedef struct packed {
    logic       latch_in;
    logic       do_cmd;
    logic       sol_init;
    logic       sel_clear;
    logic       sel_step;
    logic       settle;
    logic       rlx_step;
    logic [VIdxW-1:0] idx;
    logic       out_load;
    logic       out_cmd;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    logic       found;
    logic       ok_exists;
    logic [2:0] kind;
  } stat_t;
endpackage

FILE: rtl/gsp_datapath.sv
// Datapath of the shortest path engine: graph store, distance table and output register.
module gsp_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gsp_pkg::cmd_t        cmd_i,
  output gsp_pkg::stat_t       stat_o,
  input  logic [2:0]           kind_i,
  input  logic [3:0]           source_vertex_i,
  input  logic [3:0]           target_vertex_i,
  input  logic [15:0]          edge_weight_i,
  input  logic                 both_ways_i,
  output logic [1:0]           status_o,
  output logic [3:0]           vertex_index_o,
  output logic [19:0]          distance_o,
  output logic [3:0]           predecessor_o,
  output logic                 has_predecessor_o,
  output logic                 reachable_o,
  output logic                 last_o
);
  import gsp_pkg::*;

  logic [2:0]       kind_q;
  logic [VIdxW-1:0] s_q, t_q;
  logic [WeightW-1:0] w_q;
  logic             both_q;
  logic [NumVerts-1:0] vpres_q;
  logic [NumVerts-1:0] epres_q [NumVerts];
  logic [WeightW-1:0]  cost_q [NumVerts*NumVerts];
  logic [DistW-1:0]    dist_q [NumVerts];
  logic [VIdxW-1:0]    par_q [NumVerts];
  logic [NumVerts-1:0] reached_q, settled_q;
  logic             found_q;
  logic [VIdxW-1:0] cur_q;
  logic [DistW-1:0] curd_q;
  logic [WeightW-1:0] rcost_q;
  logic             rvalid_q;
  logic             rev_wr_q;
  logic [VIdxW-1:0] rj_q;
  logic [1:0]       status_d;
  logic             s_ok, t_ok;
  logic [DistW-1:0] cand;

  assign s_ok = vpres_q[s_q];
  assign t_ok = vpres_q[t_q];
  assign stat_o.found = found_q;
  assign stat_o.kind = kind_q;
  assign stat_o.ok_exists = s_ok && ((kind_q != KindAddEdge && kind_q != KindRemEdge) || t_ok);
  assign cand = curd_q + DistW'(rcost_q);

  always_comb begin
    status_d = StatOk;
    case (kind_q)
      KindAddVertex: if (s_ok) status_d = StatPresent;
      KindRemVertex, KindSolve: if (!s_ok) status_d = StatNoVertex;
      KindAddEdge: begin
        if (!s_ok || !t_ok) status_d = StatNoVertex;
        else if (s_q == t_q || epres_q[s_q][t_q]) status_d = StatRefused;
      end
      KindRemEdge: if (!s_ok || !t_ok) status_d = StatNoVertex;
      default: status_d = StatOk;
    endcase
  end

  // Edge cost memory: one write and one registered read per cycle.
  // The reverse edge weight is written in the cycle after the forward one.
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_cmd && kind_q == KindAddEdge && status_d == StatOk) begin
      cost_q[{s_q, t_q}] <= w_q;
    end else if (rev_wr_q) begin
      cost_q[{t_q, s_q}] <= w_q;
    end
    rcost_q <= cost_q[{cur_q, cmd_i.idx}];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      kind_q <= kind_i;
      s_q <= source_vertex_i;
      t_q <= target_vertex_i;
      w_q <= edge_weight_i;
      both_q <= both_ways_i;
    end
    if (cmd_i.sel_clear) begin
      found_q <= 1'b0;
    end else if (cmd_i.sel_step) begin
      if (reached_q[cmd_i.idx] && !settled_q[cmd_i.idx] &&
          (!found_q || dist_q[cmd_i.idx] < curd_q)) begin
        found_q <= 1'b1;
        cur_q <= cmd_i.idx;
        curd_q <= dist_q[cmd_i.idx];
      end
    end
    rj_q <= cmd_i.idx;
    if (cmd_i.sol_init) begin
      dist_q[s_q] <= '0;
    end else if (rvalid_q && epres_q[cur_q][rj_q] && vpres_q[rj_q] && !settled_q[rj_q] &&
                 (!reached_q[rj_q] || cand < dist_q[rj_q])) begin
      dist_q[rj_q] <= cand;
      par_q[rj_q] <= cur_q;
    end
    if (cmd_i.out_load) begin
      status_o <= cmd_i.out_cmd ? status_d : StatOk;
      last_o <= cmd_i.out_last;
      if (cmd_i.out_cmd) begin
        vertex_index_o <= '0;
        distance_o <= '0;
        predecessor_o <= '0;
        has_predecessor_o <= 1'b0;
        reachable_o <= 1'b0;
      end else begin
        vertex_index_o <= cmd_i.idx;
        reachable_o <= reached_q[cmd_i.idx];
        distance_o <= reached_q[cmd_i.idx] ? dist_q[cmd_i.idx] : '0;
        has_predecessor_o <= reached_q[cmd_i.idx] && cmd_i.idx != s_q;
        predecessor_o <= (reached_q[cmd_i.idx] && cmd_i.idx != s_q) ? par_q[cmd_i.idx] : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vpres_q <= '0;
      for (int i = 0; i < NumVerts; i++) epres_q[i] <= '0;
      reached_q <= '0;
      settled_q <= '0;
      rvalid_q <= 1'b0;
      rev_wr_q <= 1'b0;
    end else begin
      rvalid_q <= cmd_i.rlx_step && kind_q == KindSolve;
      rev_wr_q <= cmd_i.do_cmd && kind_q == KindAddEdge && status_d == StatOk && both_q;
      if (cmd_i.do_cmd && status_d == StatOk) begin
        case (kind_q)
          KindAddVertex: vpres_q[s_q] <= 1'b1;
          KindRemVertex: begin
            vpres_q[s_q] <= 1'b0;
            for (int i = 0; i < NumVerts; i++) begin
              for (int j = 0; j < NumVerts; j++) begin
                if (VIdxW'(i) == s_q || VIdxW'(j) == s_q) epres_q[i][j] <= 1'b0;
              end
            end
          end
          KindAddEdge: begin
            epres_q[s_q][t_q] <= 1'b1;
            if (both_q) epres_q[t_q][s_q] <= 1'b1;
          end
          KindRemEdge: begin
            epres_q[s_q][t_q] <= 1'b0;
            if (both_q && s_q != t_q) epres_q[t_q][s_q] <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd_i.sol_init) begin
        reached_q <= NumVerts'(1) << s_q;
        settled_q <= '0;
      end else begin
        if (cmd_i.settle) settled_q[cur_q] <= 1'b1;
        if (rvalid_q && epres_q[cur_q][rj_q] && vpres_q[rj_q] && !settled_q[rj_q])
          reached_q[rj_q] <= 1'b1;
      end
    end
  end
endmodule

FILE: rtl/gsp_ctrl.sv
// Controller state machine of the shortest path engine.
module gsp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  gsp_pkg::stat_t stat_i,
  output gsp_pkg::cmd_t  cmd_o
);
  import gsp_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDec  = 3'd1;
  localparam logic [2:0] StSel  = 3'd2;
  localparam logic [2:0] StRlx  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;
  localparam logic [2:0] StWait = 3'd5;

  logic [2:0] state_q, state_d;
  logic [VIdxW:0] cnt_q, cnt_d;
  logic ov_q, ov_d;
  logic free;

  assign free = !ov_q || !out_stall_i;
  assign in_stall_o = state_q != StIdle;
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    ov_d = ov_q && out_stall_i;
    cmd_o = '0;
    cmd_o.idx = cnt_q[VIdxW-1:0];
    case (state_q)
      StIdle: if (in_valid_i) begin
        cmd_o.latch_in = 1'b1;
        state_d = StDec;
      end
      StDec: if (stat_i.kind > KindSolve) begin
        state_d = StIdle;
      end else if (stat_i.kind == KindSolve && stat_i.ok_exists) begin
        cmd_o.sol_init = 1'b1;
        cmd_o.sel_clear = 1'b1;
        cnt_d = '0;
        state_d = StSel;
      end else if (free) begin
        cmd_o.do_cmd = 1'b1;
        cmd_o.out_load = 1'b1;
        cmd_o.out_cmd = 1'b1;
        cmd_o.out_last = 1'b1;
        ov_d = 1'b1;
        state_d = StIdle;
      end
      StSel: begin
        cmd_o.sel_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (VIdxW+1)'(NumVerts-1)) begin
          cnt_d = '0;
          state_d = StWait;
        end
      end
      StWait: begin
        cnt_d = '0;
        if (stat_i.found) begin
          cmd_o.settle = 1'b1;
          state_d = StRlx;
        end else state_d = StOut;
      end
      StRlx: begin
        cmd_o.rlx_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (VIdxW+1)'(NumVerts)) begin
          cmd_o.rlx_step = 1'b0;
          cmd_o.sel_clear = 1'b1;
          cnt_d = '0;
          state_d = StSel;
        end
      end
      StOut: if (free) begin
        cmd_o.out_load = 1'b1;
        cmd_o.out_last = cnt_q == (VIdxW+1)'(NumVerts-1);
        ov_d = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (VIdxW+1)'(NumVerts-1)) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      ov_q <= ov_d;
    end
  end
endmodule

FILE: rtl/graph_shortest_path_engine.sv
// Top level of the graph store with single-source shortest path solve.
// A command item of a known kind has its one status result loaded into the output
// register in the decode state once that register is free, and the next item can be
// taken in the idle state after that; an unknown kind gives no result. A solve runs a
// selection sweep over the 16 vertex slots and a decision state, then a relaxation
// sweep for each settled vertex, reading the edge cost memory one entry a cycle, and
// ends with a last selection sweep and decision state before it emits 16 results. The
// next item is taken once the current item's last result is in the output register.
module graph_shortest_path_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [3:0]  source_vertex_i,
  input  logic [3:0]  target_vertex_i,
  input  logic [15:0] edge_weight_i,
  input  logic        both_ways_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [3:0]  vertex_index_o,
  output logic [19:0] distance_o,
  output logic [3:0]  predecessor_o,
  output logic        has_predecessor_o,
  output logic        reachable_o,
  output logic        last_o
);
  import gsp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  gsp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  gsp_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .kind_i, .source_vertex_i,
    .target_vertex_i, .edge_weight_i, .both_ways_i, .status_o, .vertex_index_o,
    .distance_o, .predecessor_o, .has_predecessor_o, .reachable_o, .last_o
  );
endmodule

FILE: rtl/gsp_checker.sv
// Port checker of the shortest path engine and its bind statement.
module gsp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] status_o,
  input logic       has_predecessor_o,
  input logic       reachable_o,
  input logic       last_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(last_o))
    else $error("stalled item changed");
  a_pred: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_predecessor_o |-> reachable_o)
    else $error("predecessor without reach");
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != 2'd0 |-> last_o && !reachable_o)
    else $error("error item malformed");
endmodule

bind graph_shortest_path_engine gsp_checker u_chk (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .status_o, .has_predecessor_o,
  .reachable_o, .last_o
);

FILE: tb/tb.sv
// Self-checking testbench of the graph shortest path engine with a built-in graph predictor.
module tb;
  import gsp_pkg::*;

  localparam int Slots = 16;
  localparam int WatchLimit = 20000;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  vidx;
    logic [19:0] distance;
    logic [3:0]  pred;
    logic        has_pred;
    logic        reach;
    logic        last;
  } result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  kind_i;
  logic [3:0]  source_vertex_i;
  logic [3:0]  target_vertex_i;
  logic [15:0] edge_weight_i;
  logic        both_ways_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  status_o;
  logic [3:0]  vertex_index_o;
  logic [19:0] distance_o;
  logic [3:0]  predecessor_o;
  logic        has_predecessor_o;
  logic        reachable_o;
  logic        last_o;

  graph_shortest_path_engine dut (.*);

  logic          vert_on [Slots];
  logic          edge_on [Slots][Slots];
  logic [15:0]   edge_w [Slots][Slots];
  result_t       expected_q [$];
  int            send_idle_pct;
  int            recv_stall_pct;
  int            hold_cycles;
  int            quiet_cycles;
  bit            failed;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic result_t status_result(logic [1:0] st);
    result_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void add_expected(result_t r);
    expected_q.insert(expected_q.size(), r);
  endfunction

  // Apply one item to the graph copy and queue the results it should produce.
  function automatic void predict_graph(logic [2:0] k, logic [3:0] s, logic [3:0] t,
                                        logic [15:0] w, logic bw);
    logic       reached [Slots];
    logic       done [Slots];
    logic [19:0] path_len [Slots];
    logic [3:0] par [Slots];
    logic       found;
    int         cur;
    logic [19:0] cand;
    result_t    r;
    case (k)
      KindAddVertex: begin
        if (vert_on[s]) add_expected(status_result(StatPresent));
        else begin
          vert_on[s] = 1'b1;
          add_expected(status_result(StatOk));
        end
      end
      KindRemVertex: begin
        if (!vert_on[s]) add_expected(status_result(StatNoVertex));
        else begin
          for (int i = 0; i < Slots; i++) begin
            edge_on[s][i] = 1'b0;
            edge_on[i][s] = 1'b0;
          end
          vert_on[s] = 1'b0;
          add_expected(status_result(StatOk));
        end
      end
      KindAddEdge: begin
        if (!vert_on[s] || !vert_on[t]) add_expected(status_result(StatNoVertex));
        else if (s == t || edge_on[s][t]) add_expected(status_result(StatRefused));
        else begin
          edge_on[s][t] = 1'b1;
          edge_w[s][t] = w;
          if (bw) begin
            edge_on[t][s] = 1'b1;
            edge_w[t][s] = w;
          end
          add_expected(status_result(StatOk));
        end
      end
      KindRemEdge: begin
        if (!vert_on[s] || !vert_on[t]) add_expected(status_result(StatNoVertex));
        else begin
          edge_on[s][t] = 1'b0;
          if (bw) edge_on[t][s] = 1'b0;
          add_expected(status_result(StatOk));
        end
      end
      KindSolve: begin
        if (!vert_on[s]) add_expected(status_result(StatNoVertex));
        else begin
          for (int i = 0; i < Slots; i++) begin
            reached[i] = 1'b0;
            done[i] = 1'b0;
            path_len[i] = '0;
            par[i] = '0;
          end
          reached[s] = 1'b1;
          for (int rnd = 0; rnd < Slots; rnd++) begin
            found = 1'b0;
            cur = 0;
            for (int i = 0; i < Slots; i++)
              if (reached[i] && !done[i] && (!found || path_len[i] < path_len[cur])) begin
                cur = i;
                found = 1'b1;
              end
            if (!found) break;
            done[cur] = 1'b1;
            for (int j = 0; j < Slots; j++) begin
              if (!edge_on[cur][j] || !vert_on[j] || done[j]) continue;
              cand = path_len[cur] + 20'(edge_w[cur][j]);
              if (!reached[j] || cand < path_len[j]) begin
                reached[j] = 1'b1;
                path_len[j] = cand;
                par[j] = 4'(cur);
              end
            end
          end
          for (int i = 0; i < Slots; i++) begin
            r = '0;
            r.status = StatOk;
            r.vidx = 4'(i);
            r.reach = reached[i];
            r.distance = reached[i] ? path_len[i] : '0;
            r.has_pred = reached[i] && (i != s);
            r.pred = r.has_pred ? par[i] : '0;
            r.last = (i == Slots - 1);
            add_expected(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(logic [2:0] k, logic [3:0] s, logic [3:0] t,
                           logic [15:0] w, logic bw);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= k;
    source_vertex_i <= s;
    target_vertex_i <= t;
    edge_weight_i <= w;
    both_ways_i <= bw;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_graph(k, s, t, w, bw);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic test_commands();
    send_item(KindSolve, 4'd0, 4'd0, 16'd0, 1'b0);
    send_item(KindRemVertex, 4'd3, 4'd0, 16'd0, 1'b0);
    send_item(KindAddEdge, 4'd0, 4'd1, 16'd5, 1'b0);
    for (int i = 0; i < 4; i++) send_item(KindAddVertex, 4'(i), 4'd0, 16'd0, 1'b0);
    send_item(KindAddVertex, 4'd15, 4'd0, 16'd0, 1'b0);
    send_item(KindAddVertex, 4'd0, 4'd0, 16'd0, 1'b0);
    send_item(KindAddEdge, 4'd2, 4'd2, 16'd1, 1'b0);
    send_item(KindAddEdge, 4'd0, 4'd1, 16'hffff, 1'b1);
    send_item(KindAddEdge, 4'd0, 4'd1, 16'd3, 1'b0);
    send_item(KindAddEdge, 4'd1, 4'd0, 16'd7, 1'b1);
    send_item(KindAddEdge, 4'd0, 4'd2, 16'd2, 1'b0);
    send_item(KindAddEdge, 4'd2, 4'd1, 16'd5, 1'b0);
    send_item(KindAddEdge, 4'd1, 4'd15, 16'hffff, 1'b0);
    send_item(KindAddEdge, 4'd0, 4'd3, 16'd7, 1'b0);
    send_item(KindRemEdge, 4'd3, 4'd2, 16'd0, 1'b1);
    send_item(KindRemEdge, 4'd0, 4'd9, 16'd0, 1'b0);
    send_item(KindSolve, 4'd0, 4'd0, 16'd0, 1'b0);
    send_item(3'd5, 4'd0, 4'd0, 16'd0, 1'b0);
    send_item(3'd7, 4'd15, 4'd15, 16'hffff, 1'b1);
    send_item(KindRemEdge, 4'd1, 4'd0, 16'd0, 1'b1);
    send_item(KindRemVertex, 4'd2, 4'd0, 16'd0, 1'b0);
    send_item(KindSolve, 4'd15, 4'd0, 16'd0, 1'b0);
    send_item(KindSolve, 4'd0, 4'd0, 16'd0, 1'b0);
    drain_results();
  endtask

  task automatic test_random_graphs(int count);
    int sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 15)
        send_item(KindAddVertex, 4'($urandom_range(15)), 4'($urandom), 16'($urandom), 1'($urandom));
      else if (sel < 22)
        send_item(KindRemVertex, 4'($urandom_range(15)), 4'($urandom), 16'($urandom), 1'($urandom));
      else if (sel < 60)
        send_item(KindAddEdge, 4'($urandom_range(15)), 4'($urandom_range(15)),
                  ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40)),
                  1'($urandom));
      else if (sel < 72)
        send_item(KindRemEdge, 4'($urandom_range(15)), 4'($urandom_range(15)),
                  16'($urandom), 1'($urandom));
      else if (sel < 96)
        send_item(KindSolve, 4'($urandom_range(15)), 4'($urandom), 16'($urandom), 1'($urandom));
      else
        send_item(3'($urandom_range(7, 5)), 4'($urandom), 4'($urandom), 16'($urandom),
                  1'($urandom));
    end
    drain_results();
  endtask

  task automatic test_backpressure();
    hold_cycles = 1500;
    for (int i = 0; i < 6; i++)
      send_item(KindAddVertex, 4'($urandom_range(15)), 4'd0, 16'd0, 1'b0);
    send_item(KindSolve, 4'($urandom_range(15)), 4'd0, 16'd0, 1'b0);
    drain_results();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {status_o, vertex_index_o, distance_o, predecessor_o, has_predecessor_o,
             reachable_o, last_o};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        failed = 1'b1;
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status || got.vidx !== want.vidx ||
            got.distance !== want.distance ||
            got.pred !== want.pred || got.has_pred !== want.has_pred ||
            got.reach !== want.reach || got.last !== want.last) begin
          $display("%0t: mismatch, expected st=%0d idx=%0d dist=%0d pred=%0d hp=%0b re=%0b last=%0b",
                   $time, want.status, want.vidx, want.distance, want.pred, want.has_pred,
                   want.reach, want.last);
          $display("%0t:           actual st=%0d idx=%0d dist=%0d pred=%0d hp=%0b re=%0b last=%0b",
                   $time, got.status, got.vidx, got.distance, got.pred, got.has_pred,
                   got.reach, got.last);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("graph_shortest_path_engine test failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < Slots; i++) begin
      vert_on[i] = 1'b0;
      for (int j = 0; j < Slots; j++) begin
        edge_on[i][j] = 1'b0;
        edge_w[i][j] = '0;
      end
    end
    failed = 1'b0;
    quiet_cycles = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    kind_i = '0;
    source_vertex_i = '0;
    target_vertex_i = '0;
    edge_weight_i = '0;
    both_ways_i = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_commands();
    test_random_graphs(20);
    send_idle_pct = 67;
    test_random_graphs(25);
    send_idle_pct = 0;
    recv_stall_pct = 67;
    test_random_graphs(25);
    send_idle_pct = 9;
    recv_stall_pct = 9;
    test_random_graphs(25);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();
    if (!failed) begin
      $display("graph_shortest_path_engine test passed");
    end else begin
      $display("graph_shortest_path_engine test failed");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/gsp_pkg.sv
rtl/gsp_datapath.sv
rtl/gsp_ctrl.sv
rtl/graph_shortest_path_engine.sv
rtl/gsp_checker.sv
tb/tb.sv
